// File: hw/rtl/rfalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfalu_pkg: shared types and codes
// Operation codes and sequencer states for the fraction ALU.
// ----------------------------------------------------------------------------
package rfalu_pkg;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;
	localparam logic [1:0] CMD_DIV = 2'd3;

	localparam int WORD_BITS = 33;
	localparam int CNT_BITS  = 6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_CHECK,
		S_GCD,
		S_GCD_UPD,
		S_DIV,
		S_RED_N,
		S_RED_D,
		S_WHOLE
	} state_t;

endpackage

// File: hw/rtl/rational_fraction_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu: signed fraction add/sub/mul/div with gcd reduction
// One 16x16 multiplier and one 33-bit restoring divider are reused under a
// small sequencer.
// ----------------------------------------------------------------------------
// Sequence: three product states and a check (a zero denominator ends there),
// then one division per Euclid step (launch, one divider step per quotient
// bit, update), then three more divisions to reduce and test for a whole.
// One transfer at a time: busy stays high until the result strobe.
// The divider's one-bit-per-cycle loop dominates the run time.
// The receiver cannot stall; done pulses one cycle. Reset returns to idle.
module rational_fraction_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] first_numerator,
	input  logic signed [15:0] first_denominator,
	input  logic signed [15:0] second_numerator,
	input  logic signed [15:0] second_denominator,
	output logic               done,
	output logic signed [32:0] result_numerator,
	output logic signed [31:0] result_denominator,
	output logic               is_whole,
	output logic               status
);

	localparam int W = rfalu_pkg::WORD_BITS;

	rfalu_pkg::state_t state_q, state_d, ret_q, lret;

	logic [1:0]         cmd_q;
	logic signed [15:0] n1_q, d1_q, n2_q, d2_q;
	logic signed [W-1:0] num_q, den_q, a_q, b_q, g_q;

	// multiplier
	logic signed [15:0] mul_a, mul_b;
	logic signed [31:0] prod;
	logic signed [W-1:0] prod_x;

	// divider
	logic [W-1:0] quo_q, dvs_q;
	logic [W:0]   rem_q, rem_sh, diff;
	logic         qbit, a_neg_q, b_neg_q;
	logic [rfalu_pkg::CNT_BITS-1:0] cnt_q;
	logic signed [W-1:0] q_signed, r_signed;

	logic                launch;
	logic signed [W-1:0] la, lb;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	assign busy = (state_q != rfalu_pkg::S_IDLE);

	always_comb begin
		mul_a = n1_q;
		mul_b = d2_q;
		case (state_q)
			rfalu_pkg::S_MUL0: begin
				mul_a = n1_q;
				mul_b = (cmd_q == rfalu_pkg::CMD_MUL) ? n2_q : d2_q;
			end
			rfalu_pkg::S_MUL1: begin
				mul_a = n2_q;
				mul_b = d1_q;
			end
			rfalu_pkg::S_MUL2: begin
				mul_a = d1_q;
				mul_b = (cmd_q == rfalu_pkg::CMD_DIV) ? n2_q : d2_q;
			end
			default: ;
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign prod_x = W'(prod);

	assign rem_sh   = {rem_q[W-1:0], quo_q[W-1]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign qbit     = !diff[W];
	assign q_signed = (a_neg_q ^ b_neg_q) ? W'(-quo_q) : W'(quo_q);
	assign r_signed = a_neg_q ? W'(-rem_q[W-1:0]) : W'(rem_q[W-1:0]);

	always_comb begin
		state_d = state_q;
		launch  = 1'b0;
		la      = a_q;
		lb      = b_q;
		lret    = rfalu_pkg::S_GCD_UPD;
		case (state_q)
			rfalu_pkg::S_IDLE:  if (start) state_d = rfalu_pkg::S_MUL0;
			rfalu_pkg::S_MUL0:  state_d = rfalu_pkg::S_MUL1;
			rfalu_pkg::S_MUL1:  state_d = rfalu_pkg::S_MUL2;
			rfalu_pkg::S_MUL2:  state_d = rfalu_pkg::S_CHECK;
			rfalu_pkg::S_CHECK: begin
				state_d = (den_q == '0) ? rfalu_pkg::S_IDLE : rfalu_pkg::S_GCD;
			end
			rfalu_pkg::S_GCD: begin
				launch  = 1'b1;
				state_d = rfalu_pkg::S_DIV;
				if (b_q == '0) begin
					la   = num_q;
					lb   = a_q;
					lret = rfalu_pkg::S_RED_N;
				end
			end
			rfalu_pkg::S_GCD_UPD: state_d = rfalu_pkg::S_GCD;
			rfalu_pkg::S_DIV: if (cnt_q == '0) state_d = ret_q;
			rfalu_pkg::S_RED_N: begin
				launch  = 1'b1;
				la      = den_q;
				lb      = g_q;
				lret    = rfalu_pkg::S_RED_D;
				state_d = rfalu_pkg::S_DIV;
			end
			rfalu_pkg::S_RED_D: begin
				launch  = 1'b1;
				la      = num_q;
				lb      = q_signed;
				lret    = rfalu_pkg::S_WHOLE;
				state_d = rfalu_pkg::S_DIV;
			end
			rfalu_pkg::S_WHOLE: state_d = rfalu_pkg::S_IDLE;
			default: state_d = rfalu_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfalu_pkg::S_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= ((state_q == rfalu_pkg::S_CHECK) && (den_q == '0)) ||
			           (state_q == rfalu_pkg::S_WHOLE);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rfalu_pkg::S_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
					n1_q  <= first_numerator;
					d1_q  <= first_denominator;
					n2_q  <= second_numerator;
					d2_q  <= second_denominator;
				end
			end
			rfalu_pkg::S_MUL0: num_q <= prod_x;
			rfalu_pkg::S_MUL1: begin
				if (cmd_q == rfalu_pkg::CMD_ADD) num_q <= num_q + prod_x;
				else if (cmd_q == rfalu_pkg::CMD_SUB) num_q <= num_q - prod_x;
			end
			rfalu_pkg::S_MUL2: den_q <= prod_x;
			rfalu_pkg::S_CHECK: begin
				a_q <= num_q;
				b_q <= den_q;
				if (den_q == '0) begin
					result_numerator   <= '0;
					result_denominator <= '0;
					is_whole           <= 1'b0;
					status             <= 1'b1;
				end
			end
			rfalu_pkg::S_GCD: if (b_q == '0) g_q <= a_q;
			rfalu_pkg::S_GCD_UPD: begin
				a_q <= b_q;
				b_q <= r_signed;
			end
			rfalu_pkg::S_DIV: begin
				quo_q <= {quo_q[W-2:0], qbit};
				rem_q <= qbit ? diff : rem_sh;
				cnt_q <= cnt_q - 1'b1;
			end
			rfalu_pkg::S_RED_N: num_q <= q_signed;
			rfalu_pkg::S_RED_D: den_q <= q_signed;
			rfalu_pkg::S_WHOLE: begin
				status <= 1'b0;
				if (rem_q == '0) begin
					result_numerator   <= q_signed;
					result_denominator <= 32'sd1;
					is_whole           <= 1'b1;
				end else begin
					result_numerator   <= num_q;
					result_denominator <= den_q[31:0];
					is_whole           <= 1'b0;
				end
			end
			default: ;
		endcase
		// divider load overrides the per-state updates above
		if (launch) begin
			a_neg_q <= la[W-1];
			b_neg_q <= lb[W-1];
			quo_q   <= mag(la);
			dvs_q   <= mag(lb);
			rem_q   <= '0;
			cnt_q   <= rfalu_pkg::CNT_BITS'(W - 1);
			ret_q   <= lret;
		end
	end

endmodule

// File: verif/rational_fraction_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_tb: self-checking bench for the fraction ALU
// Drives add/sub/mul/div commands through the start/busy handshake, predicts
// the gcd-reduced fraction for each one and compares every done strobe with
// the oldest prediction. Directed corner cases first, then random traffic.
// ----------------------------------------------------------------------------
module rational_fraction_alu_tb;

	typedef struct {
		logic signed [32:0] num;
		logic signed [31:0] den;
		logic               whole;
		logic               status;
	} frac_result_t;

	localparam int MAX_CYCLES = 5_000_000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic signed [15:0] first_numerator;
	logic signed [15:0] first_denominator;
	logic signed [15:0] second_numerator;
	logic signed [15:0] second_denominator;
	logic               done;
	logic signed [32:0] result_numerator;
	logic signed [31:0] result_denominator;
	logic               is_whole;
	logic               status;

	frac_result_t expected_fracs[$];
	int           error_count;
	int           cycle_count;
	int           sent_count;
	int           checked_count;
	int           zero_den_count;
	bit           gaps_on;

	rational_fraction_alu dut (
		.clk, .arst_n, .start, .busy, .cmd,
		.first_numerator, .first_denominator, .second_numerator, .second_denominator,
		.done, .result_numerator, .result_denominator, .is_whole, .status
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Euclid with truncating remainder; the gcd keeps the loop's sign
	function automatic frac_result_t reduce_fraction(logic [1:0] op, logic signed [15:0] n1,
			logic signed [15:0] d1, logic signed [15:0] n2, logic signed [15:0] d2);
		longint num, den, a, b, t;
		frac_result_t r;
		case (op)
			rfalu_pkg::CMD_ADD: begin
				num = n1 * d2 + n2 * d1; den = longint'(d1) * d2;
			end
			rfalu_pkg::CMD_SUB: begin
				num = n1 * d2 - n2 * d1; den = longint'(d1) * d2;
			end
			rfalu_pkg::CMD_MUL: begin
				num = longint'(n1) * n2; den = longint'(d1) * d2;
			end
			default: begin num = longint'(n1) * d2; den = longint'(d1) * n2; end
		endcase
		r = '{num: '0, den: '0, whole: 1'b0, status: 1'b1};
		if (den == 0)
			return r;
		a = num;
		b = den;
		while (b != 0) begin
			t = b;
			b = a % b;
			a = t;
		end
		num = num / a;
		den = den / a;
		r.status = 1'b0;
		if (num % den == 0) begin
			num = num / den;
			den = 1;
			r.whole = 1'b1;
		end
		r.num = num[32:0];
		r.den = den[31:0];
		return r;
	endfunction

	task automatic send_fraction_op(logic [1:0] op, logic [15:0] n1, logic [15:0] d1,
			logic [15:0] n2, logic [15:0] d2);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		first_numerator <= n1;
		first_denominator <= d1;
		second_numerator <= n2;
		second_denominator <= d2;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_fracs.push_back(reduce_fraction(op, n1, d1, n2, d2));
		sent_count++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 16'(signed'($urandom_range(0, 20)) - 10);
			1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [15:0] ext[6];
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h0002};
		for (int op = 0; op < 4; op++) begin
			send_fraction_op(op[1:0], 16'd1, 16'd2, 16'd1, 16'd3);
			send_fraction_op(op[1:0], 16'h8000, 16'h8000, 16'h8000, 16'hffff);
			send_fraction_op(op[1:0], ext[op], 16'd0, ext[op + 1], ext[op + 2]);
			send_fraction_op(op[1:0], 16'd0, 16'd5, 16'd0, 16'd7);
			send_fraction_op(op[1:0], 16'h7fff, 16'h7fff, 16'hffff, 16'hfffe);
		end
		// negative denominator case: 1 / -2
		send_fraction_op(rfalu_pkg::CMD_MUL, 16'd1, 16'hfffe, 16'd1, 16'd1);
		send_fraction_op(rfalu_pkg::CMD_DIV, 16'h8000, 16'd1, 16'hffff, 16'd1);
		send_fraction_op(rfalu_pkg::CMD_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_fraction_op(2'($urandom), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
	endtask

	task automatic test_back_to_back(int count);
		gaps_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_fraction_op(2'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
	endtask

	always @(posedge clk) begin
		frac_result_t e;
		if (arst_n && done) begin
			if (expected_fracs.size() == 0) begin
				$error("result transfer with no command outstanding");
				error_count++;
			end else begin
				e = expected_fracs.pop_front();
				checked_count++;
				if (e.status) zero_den_count++;
				if (result_numerator !== e.num) begin
					$error("result_numerator exp %0d got %0d", e.num, result_numerator);
					error_count++;
				end
				if (result_denominator !== e.den) begin
					$error("result_denominator exp %0d got %0d", e.den, result_denominator);
					error_count++;
				end
				if (is_whole !== e.whole) begin
					$error("is_whole exp %0b got %0b", e.whole, is_whole);
					error_count++;
				end
				if (status !== e.status) begin
					$error("status exp %0b got %0b", e.status, status);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = rfalu_pkg::CMD_ADD;
		first_numerator = '0;
		first_denominator = '0;
		second_numerator = '0;
		second_denominator = '0;
		error_count = 0;
		cycle_count = 0;
		sent_count = 0;
		checked_count = 0;
		zero_den_count = 0;
		gaps_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(480);
		test_back_to_back(80);
		while (expected_fracs.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d commands sent, %0d results checked (%0d zero-denominator errors)",
			sent_count, checked_count, zero_den_count);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: rational_fraction_alu.f
hw/rtl/rfalu_pkg.sv
hw/rtl/rational_fraction_alu.sv
verif/rational_fraction_alu_tb.sv
